// ===== sv/hight_pkg.sv =====
// Shared types, constants and round functions for the HIGHT cipher core.
package hight_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int NSUB       = 4 * ROUNDS_DEF;
    localparam int BLK_W      = 64;
    localparam int KEY_W      = 128;
    localparam int CFG_W      = 64;
    localparam int CFG_AW     = 1;
    localparam logic [7:0] DELTA_SEED = 8'h5A;

    typedef logic [7:0] t_byte;
    typedef t_byte [NSUB-1:0] t_delta_tab;

    typedef enum logic [CFG_AW-1:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    function automatic t_delta_tab gen_delta();
        t_delta_tab tab;
        logic [7:0] d;
        logic       nb;
        d = DELTA_SEED;
        for (int i = 0; i < NSUB; i++) begin
            tab[i] = d;
            nb = d[3] ^ d[0];
            d = {1'b0, nb, d[6:1]};
        end
        return tab;
    endfunction

    localparam t_delta_tab DELTA = gen_delta();

    function automatic t_byte f0(input t_byte x);
        return {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[0], x[7:1]};
    endfunction

    function automatic t_byte f1(input t_byte x);
        return {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ {x[1:0], x[7:2]};
    endfunction

    // subkey idx = master key byte + delta; idx is a constant at every call
    function automatic t_byte sk_byte(input logic [KEY_W-1:0] key, input int idx);
        int i;
        int j;
        int m;
        i = idx / 16;
        j = idx % 16;
        if (j < 8) begin
            m = (j - i) & 7;
        end else begin
            m = ((j - 8 - i) & 7) + 8;
        end
        return key[8*m +: 8] + DELTA[idx];
    endfunction

endpackage

// ===== sv/hight_cell.sv =====
// One round cell of the HIGHT pipeline; serves an encrypt or decrypt round.
module hight_cell #(
    parameter int ROUNDS = 32,
    parameter int IDX    = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hight_pkg::KEY_W-1:0]   i_key,
    input  hight_pkg::t_ctl               i_ctl,
    input  logic [hight_pkg::BLK_W-1:0]   i_state,
    output hight_pkg::t_ctl               o_ctl,
    output logic [hight_pkg::BLK_W-1:0]   o_state
);
    import hight_pkg::*;

    localparam int ENC_R = IDX;
    localparam int DEC_R = ROUNDS - 1 - IDX;

    t_ctl              r_ctl;
    logic [BLK_W-1:0]  r_state;
    logic [BLK_W-1:0]  n_state;

    always_comb begin
        t_byte s [8];
        t_byte e [8];
        t_byte d [8];
        t_byte k [4];
        for (int b = 0; b < 8; b++) begin
            s[b] = i_state[8*b +: 8];
        end
        for (int q = 0; q < 4; q++) begin
            k[q] = (i_ctl.op == OP_DECRYPT) ? sk_byte(i_key, 4*DEC_R + q)
                                            : sk_byte(i_key, 4*ENC_R + q);
        end
        // encrypt round
        if (ENC_R == ROUNDS - 1) begin
            e[0] = s[0];
            e[2] = s[2];
            e[4] = s[4];
            e[6] = s[6];
            e[1] = s[1] + (f1(s[0]) ^ k[0]);
            e[3] = s[3] ^ (f0(s[2]) + k[1]);
            e[5] = s[5] + (f1(s[4]) ^ k[2]);
            e[7] = s[7] ^ (f0(s[6]) + k[3]);
        end else begin
            e[1] = s[0];
            e[3] = s[2];
            e[5] = s[4];
            e[7] = s[6];
            e[0] = s[7] ^ (f0(s[6]) + k[3]);
            e[2] = s[1] + (f1(s[0]) ^ k[0]);
            e[4] = s[3] ^ (f0(s[2]) + k[1]);
            e[6] = s[5] + (f1(s[4]) ^ k[2]);
        end
        // decrypt round
        if (DEC_R == ROUNDS - 1) begin
            d[0] = s[0];
            d[2] = s[2];
            d[4] = s[4];
            d[6] = s[6];
            d[1] = s[1] - (f1(s[0]) ^ k[0]);
            d[3] = s[3] ^ (f0(s[2]) + k[1]);
            d[5] = s[5] - (f1(s[4]) ^ k[2]);
            d[7] = s[7] ^ (f0(s[6]) + k[3]);
        end else begin
            d[0] = s[1];
            d[2] = s[3];
            d[4] = s[5];
            d[6] = s[7];
            d[7] = s[0] ^ (f0(s[7]) + k[3]);
            d[1] = s[2] - (f1(s[1]) ^ k[0]);
            d[3] = s[4] ^ (f0(s[3]) + k[1]);
            d[5] = s[6] - (f1(s[5]) ^ k[2]);
        end
        for (int b = 0; b < 8; b++) begin
            n_state[8*b +: 8] = (i_ctl.op == OP_DECRYPT) ? d[b] : e[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;

endmodule

// ===== sv/hight_block_cipher.sv =====
// HIGHT cipher core: whitening, a chain of round cells, output whitening.
// One block enters per cycle with start while busy is low; busy is high only
// during reset and the cycle after it. Each result appears on o_out_block with
// o_valid high for one cycle, after its block has passed one registered cell
// per round and then the output register.
// Results cannot be held off. Key registers are written through the config
// port and must not change while blocks are in flight.
module hight_block_cipher #(
    parameter int ROUNDS = hight_pkg::ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_opcode,
    input  logic [hight_pkg::BLK_W-1:0]   i_in_block,
    output logic                          o_valid,
    output logic [hight_pkg::BLK_W-1:0]   o_out_block,
    input  logic                          i_cfg_we,
    input  logic [hight_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [hight_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import hight_pkg::*;

    logic [CFG_W-1:0]  r_key_low;
    logic [CFG_W-1:0]  r_key_high;
    logic [KEY_W-1:0]  key;
    logic              r_busy;
    logic              r_valid;
    logic [BLK_W-1:0]  r_out;
    logic [BLK_W-1:0]  n_out;
    logic [BLK_W-1:0]  in_wht;

    t_ctl              ctl   [ROUNDS+1];
    logic [BLK_W-1:0]  state [ROUNDS+1];

    assign key = {r_key_high, r_key_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                REG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // input whitening: wk0..3 = key bytes 12..15, wk4..7 = key bytes 0..3
    always_comb begin
        in_wht = i_in_block;
        if (i_opcode == OP_DECRYPT) begin
            in_wht[7:0]   = i_in_block[7:0]   - key[7:0];
            in_wht[23:16] = i_in_block[23:16] ^ key[15:8];
            in_wht[39:32] = i_in_block[39:32] - key[23:16];
            in_wht[55:48] = i_in_block[55:48] ^ key[31:24];
        end else begin
            in_wht[7:0]   = i_in_block[7:0]   + key[103:96];
            in_wht[23:16] = i_in_block[23:16] ^ key[111:104];
            in_wht[39:32] = i_in_block[39:32] + key[119:112];
            in_wht[55:48] = i_in_block[55:48] ^ key[127:120];
        end
    end

    assign ctl[0]   = '{valid: i_start && !r_busy, op: t_op'(i_opcode)};
    assign state[0] = in_wht;

    for (genvar c = 0; c < ROUNDS; c++) begin : g_cell
        hight_cell #(
            .ROUNDS (ROUNDS),
            .IDX    (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (key),
            .i_ctl   (ctl[c]),
            .i_state (state[c]),
            .o_ctl   (ctl[c+1]),
            .o_state (state[c+1])
        );
    end

    // output whitening
    always_comb begin
        n_out = state[ROUNDS];
        if (ctl[ROUNDS].op == OP_DECRYPT) begin
            n_out[7:0]   = state[ROUNDS][7:0]   - key[103:96];
            n_out[23:16] = state[ROUNDS][23:16] ^ key[111:104];
            n_out[39:32] = state[ROUNDS][39:32] - key[119:112];
            n_out[55:48] = state[ROUNDS][55:48] ^ key[127:120];
        end else begin
            n_out[7:0]   = state[ROUNDS][7:0]   + key[7:0];
            n_out[23:16] = state[ROUNDS][23:16] ^ key[15:8];
            n_out[39:32] = state[ROUNDS][39:32] + key[23:16];
            n_out[55:48] = state[ROUNDS][55:48] ^ key[31:24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctl[ROUNDS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_busy      = r_busy;
    assign o_valid     = r_valid;
    assign o_out_block = r_out;

endmodule

// ===== sv/hight_chk.sv =====
// Port-level checker for the HIGHT core, bound to the top level.
module hight_chk #(
    parameter int ROUNDS = hight_pkg::ROUNDS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);
    localparam int LAT = ROUNDS + 1;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("accepted item produced no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result without an accepted item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result during reset");

    a_ready_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |=> !o_busy)
        else $error("busy stuck after reset");

endmodule

bind hight_block_cipher hight_chk #(
    .ROUNDS (ROUNDS)
) u_hight_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

// ===== test/tb_hight_block_cipher.sv =====
// Self-checking testbench for the HIGHT cipher core: predicted blocks vs. DUT results.
module tb_hight_block_cipher;
    import hight_pkg::*;

    typedef struct {
        t_op         op;
        logic [63:0] din;
        logic [63:0] dout;
    } t_block_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic        i_opcode = 1'b0;
    logic [63:0] i_in_block = '0;
    logic        o_valid;
    logic [63:0] o_out_block;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [63:0] i_cfg_wdata = '0;

    t_block_exp  expected_blocks[$];
    logic [63:0] key_lo_q = '0;
    logic [63:0] key_hi_q = '0;
    logic [63:0] last_out = '0;
    int          errors = 0;
    bit          no_idle = 1'b0;

    hight_block_cipher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_opcode    (i_opcode),
        .i_in_block  (i_in_block),
        .o_valid     (o_valid),
        .o_out_block (o_out_block),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] mix0(input logic [7:0] x);
        return rotl(x, 1) ^ rotl(x, 2) ^ rotl(x, 7);
    endfunction

    function automatic logic [7:0] mix1(input logic [7:0] x);
        return rotl(x, 3) ^ rotl(x, 4) ^ rotl(x, 6);
    endfunction

    function automatic logic [63:0] hight_transform(input t_op op, input logic [63:0] blk,
                                                    input logic [63:0] klo,
                                                    input logic [63:0] khi);
        logic [7:0]  mk[16];
        logic [7:0]  wk[8];
        logic [7:0]  sk[128];
        logic [7:0]  dl[128];
        logic [7:0]  s[8];
        logic [7:0]  t[8];
        logic [7:0]  d;
        logic [63:0] res;
        int          m;
        for (int i = 0; i < 8; i++) begin
            mk[i]     = klo[8*i +: 8];
            mk[i + 8] = khi[8*i +: 8];
            s[i]      = blk[8*i +: 8];
        end
        d = 8'h5A;
        for (int i = 0; i < 128; i++) begin
            dl[i] = d;
            d = {1'b0, d[3] ^ d[0], d[6:1]};
        end
        for (int i = 0; i < 4; i++) begin
            wk[i]     = mk[12 + i];
            wk[i + 4] = mk[i];
        end
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                m = (j - i) & 7;
                sk[16*i + j]     = mk[m] + dl[16*i + j];
                sk[16*i + j + 8] = mk[m + 8] + dl[16*i + j + 8];
            end
        end
        if (op == OP_ENCRYPT) begin
            s[0] = s[0] + wk[0];
            s[2] = s[2] ^ wk[1];
            s[4] = s[4] + wk[2];
            s[6] = s[6] ^ wk[3];
            for (int r = 0; r < 31; r++) begin
                t = s;
                s[1] = t[0];
                s[3] = t[2];
                s[5] = t[4];
                s[7] = t[6];
                s[0] = t[7] ^ (mix0(t[6]) + sk[4*r + 3]);
                s[2] = t[1] + (mix1(t[0]) ^ sk[4*r]);
                s[4] = t[3] ^ (mix0(t[2]) + sk[4*r + 1]);
                s[6] = t[5] + (mix1(t[4]) ^ sk[4*r + 2]);
            end
            s[1] = s[1] + (mix1(s[0]) ^ sk[124]);
            s[3] = s[3] ^ (mix0(s[2]) + sk[125]);
            s[5] = s[5] + (mix1(s[4]) ^ sk[126]);
            s[7] = s[7] ^ (mix0(s[6]) + sk[127]);
            s[0] = s[0] + wk[4];
            s[2] = s[2] ^ wk[5];
            s[4] = s[4] + wk[6];
            s[6] = s[6] ^ wk[7];
        end else begin
            s[0] = s[0] - wk[4];
            s[2] = s[2] ^ wk[5];
            s[4] = s[4] - wk[6];
            s[6] = s[6] ^ wk[7];
            s[1] = s[1] - (mix1(s[0]) ^ sk[124]);
            s[3] = s[3] ^ (mix0(s[2]) + sk[125]);
            s[5] = s[5] - (mix1(s[4]) ^ sk[126]);
            s[7] = s[7] ^ (mix0(s[6]) + sk[127]);
            for (int r = 30; r >= 0; r--) begin
                t = s;
                s[0] = t[1];
                s[2] = t[3];
                s[4] = t[5];
                s[6] = t[7];
                s[7] = t[0] ^ (mix0(s[6]) + sk[4*r + 3]);
                s[1] = t[2] - (mix1(s[0]) ^ sk[4*r]);
                s[3] = t[4] ^ (mix0(s[2]) + sk[4*r + 1]);
                s[5] = t[6] - (mix1(s[4]) ^ sk[4*r + 2]);
            end
            s[0] = s[0] - wk[0];
            s[2] = s[2] ^ wk[1];
            s[4] = s[4] - wk[2];
            s[6] = s[6] ^ wk[3];
        end
        for (int i = 0; i < 8; i++) begin
            res[8*i +: 8] = s[i];
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // result checker: samples pre-edge values
    always @(posedge i_clk) begin
        t_block_exp e;
        if (i_rst_n && o_valid) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_out_block));
            end else begin
                e = expected_blocks.pop_front();
                if (o_out_block !== e.dout) begin
                    report_mismatch($sformatf("op=%0d in=%h got=%h exp=%h",
                                              e.op, e.din, o_out_block, e.dout));
                end
            end
        end
    end

    task automatic send_block(input t_op op, input logic [63:0] blk);
        t_block_exp e;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_opcode   <= op;
        i_in_block <= blk;
        do @(posedge i_clk); while (o_busy);
        e.op   = op;
        e.din  = blk;
        e.dout = hight_transform(op, blk, key_lo_q, key_hi_q);
        last_out = e.dout;
        expected_blocks.push_back(e);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_reg(input t_reg_idx idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == REG_KEY_LOW) begin
            key_lo_q = val;
        end else begin
            key_hi_q = val;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
        drain();
        write_key_reg(REG_KEY_LOW, lo);
        write_key_reg(REG_KEY_HIGH, hi);
    endtask

    task automatic test_reset_key();
        logic [63:0] pats[6];
        pats = '{64'h0, '1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h1, 64'h8000_0000_0000_0000};
        foreach (pats[i]) begin
            send_block(OP_ENCRYPT, pats[i]);
            send_block(OP_DECRYPT, pats[i]);
        end
    endtask

    task automatic test_key_extremes();
        set_key('1, '1);
        send_block(OP_ENCRYPT, 64'h0);
        send_block(OP_DECRYPT, '1);
        set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_block(OP_ENCRYPT, 64'h0);
        send_block(OP_DECRYPT, last_out);
        set_key('1, 64'h0);
        send_block(OP_ENCRYPT, rand_word());
        send_block(OP_DECRYPT, last_out);
        set_key(64'h0, '1);
        send_block(OP_ENCRYPT, '1);
        send_block(OP_DECRYPT, rand_word());
    endtask

    task automatic test_random_traffic();
        int   kind;
        t_op  op;
        logic [63:0] blk;
        for (int ph = 0; ph < 11; ph++) begin
            drain();
            kind = $urandom_range(0, 5);
            case (kind)
                0: set_key('0, '0);
                1: set_key('1, '1);
                2: write_key_reg(REG_KEY_LOW, rand_word());
                3: write_key_reg(REG_KEY_HIGH, rand_word());
                default: set_key(rand_word(), rand_word());
            endcase
            for (int n = 0; n < 100; n++) begin
                if (n % 25 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    op  = t_op'($urandom_range(0, 1));
                    blk = rand_word();
                end else if (kind < 9) begin
                    // previous result again: inverse op while that block is still queued, else encrypt
                    op  = (expected_blocks.size() != 0 &&
                           expected_blocks[$].op == OP_ENCRYPT) ? OP_DECRYPT : OP_ENCRYPT;
                    blk = last_out;
                end else begin
                    op = t_op'($urandom_range(0, 1));
                    for (int b = 0; b < 8; b++) begin
                        blk[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    end
                end
                send_block(op, blk);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        test_reset_key();
        test_key_extremes();
        test_random_traffic();
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_blocks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/hight_pkg.sv
sv/hight_cell.sv
sv/hight_block_cipher.sv
sv/hight_chk.sv
test/tb_hight_block_cipher.sv
